### design/lps_pkg.sv
// shared constants, codes and controller/datapath interface types
package lps_pkg;

   // pool size and derived widths
   localparam int SLOTS        = 16;
   localparam int SLOT_FIELD_W = 5;
   localparam int SLOT_IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_FIELD_MAX = (1 << SLOT_FIELD_W) - 1;
   localparam int GRANT_SLOTS  = (SLOTS < SLOT_FIELD_MAX) ? SLOTS : SLOT_FIELD_MAX;

   // data widths
   localparam int DATA_W   = 64;
   localparam int PERIOD_W = 10;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   localparam logic [PERIOD_W-1:0]     PERIOD_RESET = PERIOD_W'(1000);
   localparam logic [SLOT_FIELD_W-1:0] SLOT_NONE    = '1;

   // request modes
   localparam logic [1:0] MODE_ENTER = 2'd0;
   localparam logic [1:0] MODE_EXIT  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_DONE        = 2'd0;
   localparam logic [1:0] STAT_NO_SLOT     = 2'd1;
   localparam logic [1:0] STAT_NOT_COUNTED = 2'd2;
   localparam logic [1:0] STAT_IGNORED     = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture accepted request, launch start read
      logic exec;       // evaluate request against slot state
      logic acc;        // add pending latency to totals
      logic div_start;  // launch average division
      logic out_load;   // move result into output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic count_go;   // exit latency needs accumulating
      logic report_go;  // tick reached a report with nonzero totals
      logic div_done;   // quotient ready
      logic out_free;   // output register can take a result
   } sts_type;

endpackage

### design/lps_ram.sv
// generic single-port-write ram with registered read
module lps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lps_div.sv
// restoring divider, one quotient bit per cycle
module lps_div
   import lps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   logic [DATA_W:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DATA_W:0]    shifted;
   logic [DATA_W+1:0]  trial;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '1;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[DATA_W+1]) begin
            rem_in = trial[DATA_W:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/lps_ctrl.sv
// sequencing state machine for one request at a time
module lps_ctrl
   import lps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACC,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.count_go) begin
               state_in = ST_ACC;
            end else if (sts.report_go) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### design/lps_dp.sv
// slot pool, totals, tick counter, divider and output register
module lps_dp
   import lps_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output sts_type                        sts,
   input  logic [1:0]                     req_mode,
   input  logic signed [SLOT_FIELD_W-1:0] req_slot_in,
   input  logic [DATA_W-1:0]              req_timestamp,
   input  logic                           csr_wr_en,
   input  logic [PERIOD_W-1:0]            csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SLOT_FIELD_W-1:0] rsp_slot_out,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_report_valid,
   output logic [DATA_W-1:0]              rsp_report_calls,
   output logic [DATA_W-1:0]              rsp_report_average
);

   // captured request
   logic [1:0]              mode_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [DATA_W-1:0]       ts_ff;

   // block state
   logic [SLOTS-1:0]        busy_ff, busy_in;
   logic [DATA_W-1:0]       total_ff, total_in;
   logic [DATA_W-1:0]       count_ff, count_in;
   logic [PERIOD_W-1:0]     tick_ff, tick_in;
   logic [PERIOD_W-1:0]     period_ff;
   logic [DATA_W-1:0]       diff_ff, diff_in;

   // pending result
   logic [SLOT_FIELD_W-1:0] res_slot_ff, res_slot_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic                    res_valid_ff, res_valid_in;
   logic [DATA_W-1:0]       res_calls_ff, res_calls_in;
   logic [DATA_W-1:0]       res_avg_ff, res_avg_in;

   // output register
   logic                    out_valid_ff;
   logic [SLOT_FIELD_W-1:0] out_slot_ff;
   logic [1:0]              out_status_ff;
   logic                    out_rvalid_ff;
   logic [DATA_W-1:0]       out_calls_ff;
   logic [DATA_W-1:0]       out_avg_ff;

   logic [SLOT_IDX_W-1:0]   rd_addr;
   logic [SLOT_IDX_W-1:0]   exit_idx;
   logic [SLOT_IDX_W-1:0]   free_idx;
   logic                    free_found;
   logic                    exit_ok;
   logic [DATA_W-1:0]       start_rd;
   logic                    ram_wr;
   logic [PERIOD_W:0]       tick_next;
   logic                    tick_hit;
   logic                    div_done;
   logic [DATA_W-1:0]       quotient;

   // start timestamp store
   assign rd_addr = SLOT_IDX_W'($unsigned(req_slot_in));
   assign ram_wr  = cmd.exec && (mode_ff == MODE_ENTER) && free_found;

   lps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (free_idx),
      .wr_data (ts_ff),
      .rd_en   (cmd.load),
      .rd_addr (rd_addr),
      .rd_data (start_rd)
   );

   // lowest free grantable slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = GRANT_SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_IDX_W'(i);
         end
      end
   end

   // exit slot check: not negative, in range and busy
   assign exit_idx = SLOT_IDX_W'(slot_ff);
   assign exit_ok  = !slot_ff[SLOT_FIELD_W-1] && (32'(slot_ff) < SLOTS) && busy_ff[exit_idx];

   // tick reaching the report point
   assign tick_next = {1'b0, tick_ff} + 1'b1;
   assign tick_hit  = tick_next >= {1'b0, period_ff};

   // status towards the controller
   always_comb begin
      sts           = '0;
      sts.count_go  = (mode_ff == MODE_EXIT) && exit_ok && (start_rd < ts_ff);
      sts.report_go = (mode_ff == MODE_TICK) && tick_hit
                      && (total_ff != '0) && (count_ff != '0);
      sts.div_done  = div_done;
      sts.out_free  = !out_valid_ff || !rsp_stall;
   end

   // request evaluation and accumulation
   always_comb begin
      busy_in       = busy_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;
      diff_in       = diff_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      res_calls_in  = res_calls_ff;
      res_avg_in    = res_avg_ff;
      if (cmd.exec) begin
         res_slot_in   = SLOT_NONE;
         res_status_in = STAT_DONE;
         res_valid_in  = 1'b0;
         res_calls_in  = '0;
         res_avg_in    = '0;
         case (mode_ff)
            MODE_ENTER: begin
               if (free_found) begin
                  busy_in[free_idx] = 1'b1;
                  res_slot_in       = SLOT_FIELD_W'(free_idx);
               end else begin
                  res_status_in = STAT_NO_SLOT;
               end
            end
            MODE_EXIT: begin
               if (!exit_ok) begin
                  res_status_in = STAT_IGNORED;
               end else begin
                  busy_in[exit_idx] = 1'b0;
                  if (start_rd < ts_ff) begin
                     diff_in = ts_ff - start_rd;
                  end else begin
                     res_status_in = STAT_NOT_COUNTED;
                  end
               end
            end
            MODE_TICK: begin
               if (tick_hit) begin
                  tick_in = '0;
                  if (sts.report_go) begin
                     res_valid_in = 1'b1;
                     res_calls_in = count_ff;
                  end
               end else begin
                  tick_in = tick_next[PERIOD_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.acc) begin
         total_in = total_ff + diff_ff;
         count_in = count_ff + 1'b1;
      end
      if (div_done) begin
         res_avg_in = quotient;
      end
   end

   // average division
   lps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (total_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // control state and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         tick_ff      <= '0;
         period_ff    <= PERIOD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         total_ff <= total_in;
         count_ff <= count_in;
         tick_ff  <= tick_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         slot_ff <= $unsigned(req_slot_in);
         ts_ff   <= req_timestamp;
      end
      diff_ff       <= diff_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_valid_ff  <= res_valid_in;
      res_calls_ff  <= res_calls_in;
      res_avg_ff    <= res_avg_in;
      if (cmd.out_load) begin
         out_slot_ff   <= res_slot_ff;
         out_status_ff <= res_status_ff;
         out_rvalid_ff <= res_valid_ff;
         out_calls_ff  <= res_calls_ff;
         out_avg_ff    <= res_avg_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_slot_out       = $signed(out_slot_ff);
   assign rsp_status         = out_status_ff;
   assign rsp_report_valid   = out_rvalid_ff;
   assign rsp_report_calls   = out_calls_ff;
   assign rsp_report_average = out_avg_ff;

endmodule

### design/latency_profiler_slots.sv
// top level of the slot-based call latency profiler
// The profiler handles one request at a time. For an enter, an exit that is not
// counted, an ignored exit, a no-op or a tick without report, the request is
// evaluated and its result is then moved into the output register. A counted
// exit adds its latency to the total in a state of its own, after the stored
// start has been read from a registered memory. A tick that produces a report
// waits for the 64-bit restoring divider, which forms the average one bit per
// cycle. A new request is accepted as soon as the previous one has been placed
// in the output register, even while that response still waits to be taken.
module latency_profiler_slots
   import lps_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic signed [SLOT_FIELD_W-1:0] req_slot_in,
   input  logic [DATA_W-1:0]              req_timestamp,
   input  logic                           csr_wr_en,
   input  logic [PERIOD_W-1:0]            csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SLOT_FIELD_W-1:0] rsp_slot_out,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_report_valid,
   output logic [DATA_W-1:0]              rsp_report_calls,
   output logic [DATA_W-1:0]              rsp_report_average
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   lps_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_slot_in        (req_slot_in),
      .req_timestamp      (req_timestamp),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slot_out       (rsp_slot_out),
      .rsp_status         (rsp_status),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_calls   (rsp_report_calls),
      .rsp_report_average (rsp_report_average)
   );

`ifndef SYNTHESIS
   // an accepted request raises the stall and holds off the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // report fields are zero unless a report is flagged
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_report_valid) |->
         (rsp_report_calls == '0) && (rsp_report_average == '0))
      else $error("report fields set without a report");

   // a granted slot always comes with done status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_slot_out != $signed(SLOT_NONE))) |-> (rsp_status == STAT_DONE))
      else $error("slot granted with a failing status");

   // output register is only loaded when it can take the result
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("response overwritten while stalled");
`endif

endmodule
